### hdl/cpen_pkg.sv
// Package for the closed polyline edge normal block.
// Holds widths, the work queue entry type and the back-end state type.
// Used by every module of the block.
package cpen_pkg;

  localparam int CoordW     = 24;
  localparam int NormW      = 16;
  localparam int DiffW      = 25;
  localparam int ProdW      = 41;
  localparam int CrossW     = 42;
  localparam int MagW       = 30;
  localparam int SqW        = 63;
  localparam int RootW      = 31;
  localparam int QuoW       = 15;
  localparam int DivW       = 45;
  localparam int StepW      = 5;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [DiffW-1:0] dx;
    logic [DiffW-1:0] dy;
    logic [DiffW-1:0] dz;
    logic [NormW-1:0] nx;
    logic [NormW-1:0] ny;
    logic [NormW-1:0] nz;
    logic             last;
  } job_t;

  typedef enum logic [3:0] {
    BkIdle,
    BkMul,
    BkAbs,
    BkNorm,
    BkSq,
    BkSqrt,
    BkDivLoad,
    BkDivStep,
    BkOut
  } bk_state_e;

endpackage

### hdl/cpen_front.sv
// Front end: accepts points, keeps the first and the held point of the polyline
// and issues one edge job per point into the work queue. Depends on cpen_pkg.
module cpen_front import cpen_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CoordW-1:0] point_x_i,
  input  logic [CoordW-1:0] point_y_i,
  input  logic [CoordW-1:0] point_z_i,
  input  logic [NormW-1:0]  normal_x_i,
  input  logic [NormW-1:0]  normal_y_i,
  input  logic [NormW-1:0]  normal_z_i,
  input  logic              last_point_i,
  input  logic              full_i,
  output logic              push_o,
  output job_t              job_o
);

  logic [CoordW-1:0] first_q [3];
  logic [CoordW-1:0] hold_q  [3];
  logic [NormW-1:0]  hnrm_q  [3];
  logic [CoordW-1:0] pt      [3];
  logic [CoordW-1:0] nxt     [3];
  logic [DiffW-1:0]  diff    [3];
  logic              have_q, have_d;
  logic              pend_q, pend_d;
  logic              accept;

  assign in_stall_o = pend_q | full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    pt[0] = point_x_i;
    pt[1] = point_y_i;
    pt[2] = point_z_i;
    for (int k = 0; k < 3; k++) begin
      nxt[k]  = accept ? pt[k] : first_q[k];
      diff[k] = {nxt[k][CoordW-1], nxt[k]} - {hold_q[k][CoordW-1], hold_q[k]};
    end
  end

  assign push_o   = (accept & have_q) | (pend_q & ~full_i);
  assign job_o.dx = diff[0];
  assign job_o.dy = diff[1];
  assign job_o.dz = diff[2];
  assign job_o.nx = hnrm_q[0];
  assign job_o.ny = hnrm_q[1];
  assign job_o.nz = hnrm_q[2];
  assign job_o.last = pend_q;

  always_comb begin
    have_d = have_q;
    pend_d = pend_q;
    if (accept) begin
      have_d = ~last_point_i;
      pend_d = last_point_i;
    end else if (pend_q && !full_i) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      have_q <= have_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q    <= pt;
      hnrm_q[0] <= normal_x_i;
      hnrm_q[1] <= normal_y_i;
      hnrm_q[2] <= normal_z_i;
      if (!have_q) begin
        first_q <= pt;
      end
    end
  end

endmodule

### hdl/cpen_fifo.sv
// Short work queue between the front end and the back end.
// Depends on cpen_pkg for the entry type.
module cpen_fifo import cpen_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### hdl/cpen_back.sv
// Back end: cross product on a shared multiplier, normalization, iterative
// square root and three restoring divisions, then the output register.
// Depends on cpen_pkg.
module cpen_back import cpen_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [NormW-1:0] edge_normal_x_o,
  output logic [NormW-1:0] edge_normal_y_o,
  output logic [NormW-1:0] edge_normal_z_o,
  output logic             degenerate_o,
  output logic             last_result_o
);

  bk_state_e state_q, state_d;
  logic [StepW-1:0]         step_q, step_d;
  logic [1:0]               comp_q, comp_d;
  logic                     last_q, last_d;
  logic                     deg_q, deg_d;
  logic signed [DiffW-1:0]  d_q [3], d_d [3];
  logic signed [NormW-1:0]  n_q [3], n_d [3];
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic signed [CrossW-1:0] c_q [3], c_d [3];
  logic [CrossW-1:0]        mag_q [3], mag_d [3];
  logic                     neg_q [3], neg_d [3];
  logic [SqW-1:0]           rem_q, rem_d, res_q, res_d, bit_q, bit_d;
  logic [DivW-1:0]          drem_q, drem_d, dsor_q, dsor_d;
  logic [QuoW-1:0]          quo_q, quo_d;
  logic [NormW-1:0]         en_q [3], en_d [3];
  logic                     out_valid_q, out_valid_d;
  logic [NormW-1:0]         out_q [3], out_d [3];
  logic                     odeg_q, odeg_d, olast_q, olast_d;

  logic signed [DiffW-1:0]  op_a;
  logic signed [NormW-1:0]  op_b;
  logic signed [ProdW-1:0]  mul_w;
  logic [CrossW-1:0]        m01, mmax;
  logic [MagW-1:0]          sq_in;
  logic [2*MagW-1:0]        sq_w;
  logic [SqW-1:0]           root_t;
  logic [QuoW-1:0]          quo_nx;
  logic                     out_free;

  always_comb begin
    case (step_q[2:0])
      3'd0:    begin op_a = d_q[1]; op_b = n_q[2]; end
      3'd1:    begin op_a = d_q[2]; op_b = n_q[1]; end
      3'd2:    begin op_a = d_q[2]; op_b = n_q[0]; end
      3'd3:    begin op_a = d_q[0]; op_b = n_q[2]; end
      3'd4:    begin op_a = d_q[0]; op_b = n_q[1]; end
      default: begin op_a = d_q[1]; op_b = n_q[0]; end
    endcase
  end

  assign mul_w    = op_a * op_b;
  assign m01      = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
  assign mmax     = (m01 > mag_q[2]) ? m01 : mag_q[2];
  assign sq_in    = mag_q[step_q[1:0]][MagW-1:0];
  assign sq_w     = sq_in * sq_in;
  assign root_t   = res_q + bit_q;
  assign quo_nx   = {quo_q[QuoW-2:0], (drem_q >= dsor_q)};
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    comp_d      = comp_q;
    last_d      = last_q;
    deg_d       = deg_q;
    d_d         = d_q;
    n_d         = n_q;
    prod_d      = prod_q;
    c_d         = c_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    rem_d       = rem_q;
    res_d       = res_q;
    bit_d       = bit_q;
    drem_d      = drem_q;
    dsor_d      = dsor_q;
    quo_d       = quo_q;
    en_d        = en_q;
    out_d       = out_q;
    odeg_d      = odeg_q;
    olast_d     = olast_q;
    out_valid_d = out_valid_q & out_stall_i;
    pop_o       = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          d_d[0]  = job_i.dx;
          d_d[1]  = job_i.dy;
          d_d[2]  = job_i.dz;
          n_d[0]  = job_i.nx;
          n_d[1]  = job_i.ny;
          n_d[2]  = job_i.nz;
          last_d  = job_i.last;
          deg_d   = 1'b0;
          step_d  = '0;
          state_d = BkMul;
        end
      end
      BkMul: begin
        prod_d = mul_w;
        case (step_q)
          StepW'(1): c_d[0] = CrossW'(prod_q);
          StepW'(2): c_d[0] = c_q[0] - CrossW'(prod_q);
          StepW'(3): c_d[1] = CrossW'(prod_q);
          StepW'(4): c_d[1] = c_q[1] - CrossW'(prod_q);
          StepW'(5): c_d[2] = CrossW'(prod_q);
          StepW'(6): c_d[2] = c_q[2] - CrossW'(prod_q);
          default:   c_d = c_q;
        endcase
        step_d = step_q + 1'b1;
        if (step_q == StepW'(6)) begin
          state_d = BkAbs;
        end
      end
      BkAbs: begin
        for (int k = 0; k < 3; k++) begin
          neg_d[k] = c_q[k][CrossW-1];
          mag_d[k] = c_q[k][CrossW-1] ? CrossW'(-c_q[k]) : c_q[k];
        end
        state_d = BkNorm;
      end
      BkNorm: begin
        if (mmax == '0) begin
          for (int k = 0; k < 3; k++) en_d[k] = '0;
          deg_d   = 1'b1;
          state_d = BkOut;
        end else if (mmax >= (CrossW'(1) << 34)) begin
          for (int k = 0; k < 3; k++) mag_d[k] = mag_q[k] >> 4;
        end else if (mmax >= (CrossW'(1) << 30)) begin
          for (int k = 0; k < 3; k++) mag_d[k] = mag_q[k] >> 1;
        end else if (mmax < (CrossW'(1) << 25)) begin
          for (int k = 0; k < 3; k++) mag_d[k] = mag_q[k] << 4;
        end else if (mmax < (CrossW'(1) << 29)) begin
          for (int k = 0; k < 3; k++) mag_d[k] = mag_q[k] << 1;
        end else begin
          rem_d   = '0;
          step_d  = '0;
          state_d = BkSq;
        end
      end
      BkSq: begin
        rem_d  = rem_q + SqW'(sq_w);
        step_d = step_q + 1'b1;
        if (step_q == StepW'(2)) begin
          res_d   = '0;
          bit_d   = SqW'(1) << 60;
          step_d  = '0;
          state_d = BkSqrt;
        end
      end
      BkSqrt: begin
        if (rem_q >= root_t) begin
          rem_d = rem_q - root_t;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(30)) begin
          comp_d  = '0;
          state_d = BkDivLoad;
        end
      end
      BkDivLoad: begin
        drem_d  = {1'b0, mag_q[comp_q][MagW-1:0], 14'b0} + DivW'(res_q[RootW-1:1]);
        dsor_d  = {res_q[RootW-1:0], 14'b0};
        quo_d   = '0;
        step_d  = '0;
        state_d = BkDivStep;
      end
      BkDivStep: begin
        quo_d  = quo_nx;
        dsor_d = dsor_q >> 1;
        if (drem_q >= dsor_q) begin
          drem_d = drem_q - dsor_q;
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(QuoW - 1)) begin
          en_d[comp_q] = neg_q[comp_q] ? NormW'(-{1'b0, quo_nx}) : {1'b0, quo_nx};
          if (comp_q == 2'd2) begin
            state_d = BkOut;
          end else begin
            comp_d  = comp_q + 1'b1;
            state_d = BkDivLoad;
          end
        end
      end
      BkOut: begin
        if (out_free) begin
          out_d       = en_q;
          odeg_d      = deg_q;
          olast_d     = last_q;
          out_valid_d = 1'b1;
          state_d     = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    comp_q  <= comp_d;
    last_q  <= last_d;
    deg_q   <= deg_d;
    d_q     <= d_d;
    n_q     <= n_d;
    prod_q  <= prod_d;
    c_q     <= c_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
    bit_q   <= bit_d;
    drem_q  <= drem_d;
    dsor_q  <= dsor_d;
    quo_q   <= quo_d;
    en_q    <= en_d;
    out_q   <= out_d;
    odeg_q  <= odeg_d;
    olast_q <= olast_d;
  end

  assign out_valid_o     = out_valid_q;
  assign edge_normal_x_o = out_q[0];
  assign edge_normal_y_o = out_q[1];
  assign edge_normal_z_o = out_q[2];
  assign degenerate_o    = odeg_q;
  assign last_result_o   = olast_q;

endmodule

### hdl/closed_polyline_edge_normal_top.sv
// Closed polyline edge normal, top level. The back end computes each result with a
// shared multiplier, normalization, 31 square root steps and three divisions; a
// degenerate result skips the root and divisions. A point is taken while the two-entry
// queue has room and no wrap edge is pending; the last point's wrap edge is issued from a
// pending flag. Reset is asynchronous, active low, and leaves no point held.
module closed_polyline_edge_normal_top import cpen_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CoordW-1:0] point_x_i,
  input  logic [CoordW-1:0] point_y_i,
  input  logic [CoordW-1:0] point_z_i,
  input  logic [NormW-1:0]  normal_x_i,
  input  logic [NormW-1:0]  normal_y_i,
  input  logic [NormW-1:0]  normal_z_i,
  input  logic              last_point_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [NormW-1:0]  edge_normal_x_o,
  output logic [NormW-1:0]  edge_normal_y_o,
  output logic [NormW-1:0]  edge_normal_z_o,
  output logic              degenerate_o,
  output logic              last_result_o
);

  logic push, full, pop, empty;
  job_t push_job, pop_job;

  cpen_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .normal_x_i   (normal_x_i),
    .normal_y_i   (normal_y_i),
    .normal_z_i   (normal_z_i),
    .last_point_i (last_point_i),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  cpen_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  cpen_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .job_i           (pop_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .edge_normal_x_o (edge_normal_x_o),
    .edge_normal_y_o (edge_normal_y_o),
    .edge_normal_z_o (edge_normal_z_o),
    .degenerate_o    (degenerate_o),
    .last_result_o   (last_result_o)
  );

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      edge_normal_x_o == '0 && edge_normal_y_o == '0 && edge_normal_z_o == '0)
    else $error("degenerate transfer carries a nonzero normal");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      $signed(edge_normal_x_o) <= 16384 && $signed(edge_normal_x_o) >= -16384 &&
      $signed(edge_normal_y_o) <= 16384 && $signed(edge_normal_y_o) >= -16384 &&
      $signed(edge_normal_z_o) <= 16384 && $signed(edge_normal_z_o) >= -16384)
    else $error("edge normal component out of unit range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("work queue written while full");

endmodule
